// File: hdl/tdi_pkg.sv
// shared types and constants of the trie dictionary block
package tdi_pkg;

   // default pool and alphabet sizes
   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   // fixed field widths
   localparam int LETTER_W = 5;
   localparam int LIMIT_W  = 9;

   // word commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // one classified letter transaction
   typedef struct packed {
      logic                command;
      logic [LETTER_W-1:0] letter;
      logic                letter_ok;
      logic                last;
   } item_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// File: hdl/tdi_ram.sv
// generic simple dual-port ram with registered read
module tdi_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tdi_front.sv
// front end: takes letter transactions, tracks word boundaries, classifies letters
module tdi_front #(
   parameter int ALPHABET_SIZE = tdi_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_command,
   input  logic [tdi_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last,
   output tdi_pkg::item_type             item
);
   import tdi_pkg::*;

   localparam logic [LIMIT_W-1:0] ALPHA_LIMIT = LIMIT_W'(ALPHABET_SIZE);

   logic mid_word_ff;
   logic mid_word_in;
   logic word_cmd_ff;
   logic word_cmd_in;
   logic cmd_eff;

   // the first letter of a word fixes its command
   assign cmd_eff = mid_word_ff ? word_cmd_ff : req_command;

   always_comb begin
      mid_word_in = mid_word_ff;
      word_cmd_in = word_cmd_ff;
      if (accept) begin
         mid_word_in = !req_last;
         word_cmd_in = cmd_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_word_ff <= 1'b0;
         word_cmd_ff <= CMD_INSERT;
      end else begin
         mid_word_ff <= mid_word_in;
         word_cmd_ff <= word_cmd_in;
      end
   end

   // classify the letter: codes at or above the alphabet size move nowhere
   always_comb begin
      item.command   = cmd_eff;
      item.letter    = req_letter;
      item.letter_ok = {{(LIMIT_W-LETTER_W){1'b0}}, req_letter} < ALPHA_LIMIT;
      item.last      = req_last;
   end

endmodule

// File: hdl/tdi_queue.sv
// two-entry queue between the front and back ends
module tdi_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tdi_pkg::item_type push_item,
   input  logic              pop,
   output tdi_pkg::head_type head,
   output logic              full
);
   import tdi_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   assign do_pop = pop && (count_ff != 2'd0);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head.valid = count_ff != 2'd0;
   assign head.item  = entry_ff[rd_ptr_ff];
   assign full       = count_ff == 2'd2;

endmodule

// File: hdl/tdi_back.sv
// back end: walks the trie in the node pool, allocates children, reports word results
module tdi_back #(
   parameter int NODE_COUNT    = tdi_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = tdi_pkg::ALPHABET_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  tdi_pkg::head_type head,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_strobe,
   output logic              rsp_found,
   output logic              rsp_status
);
   import tdi_pkg::*;

   localparam int SLOTS = NODE_COUNT * ALPHABET_SIZE;
   localparam int NW    = $clog2(NODE_COUNT);
   localparam int SW    = $clog2(SLOTS);
   localparam logic [SW-1:0] SWEEP_LAST = SW'(SLOTS - 1);
   localparam logic [SW-1:0] MARK_SPAN  = SW'(NODE_COUNT);
   localparam logic [SW-1:0] ALPHA_SW   = SW'(ALPHABET_SIZE);
   localparam logic [NW:0]   NODE_LIMIT = (NW+1)'(NODE_COUNT);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW:0]   used_ff, used_in;
   logic          failed_ff, failed_in;
   item_type      item_ff, item_in;
   logic          strobe_ff, strobe_in;
   logic          found_ff, found_in;
   logic          status_ff, status_in;

   logic [SW-1:0] slot_calc;
   logic [NW-1:0] child_rd;
   logic          mark_rd;
   logic          child_we;
   logic [SW-1:0] child_waddr;
   logic [NW-1:0] child_wdata;
   logic          mark_we;
   logic [NW-1:0] mark_waddr;
   logic          alloc;
   logic          advance;

   // slot of the head letter below the current node
   assign slot_calc = SW'(cur_ff) * ALPHA_SW + SW'(head.item.letter);

   // a letter moves the walk only if the walk is still alive and the code is a letter
   assign advance = !failed_ff && item_ff.letter_ok;
   assign alloc   = (state_ff == ST_DECIDE) && advance && (child_rd == '0)
                    && (item_ff.command == CMD_INSERT) && (used_ff < NODE_LIMIT);

   // memory write selection: clearing sweep or normal operation
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         child_we    = 1'b1;
         child_waddr = sweep_ff;
         child_wdata = '0;
         mark_we     = sweep_ff < MARK_SPAN;
         mark_waddr  = NW'(sweep_ff);
      end else begin
         child_we    = alloc;
         child_waddr = slot_ff;
         child_wdata = NW'(used_ff);
         mark_we     = (state_ff == ST_FINISH) && (item_ff.command == CMD_INSERT)
                       && !failed_ff;
         mark_waddr  = cur_ff;
      end
   end

   tdi_ram #(
      .WIDTH (NW),
      .DEPTH (SLOTS)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_we),
      .wr_addr (child_waddr),
      .wr_data (child_wdata),
      .rd_addr (slot_calc),
      .rd_data (child_rd)
   );

   tdi_ram #(
      .WIDTH (1),
      .DEPTH (NODE_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (state_ff != ST_CLEAR),
      .rd_addr (cur_ff),
      .rd_data (mark_rd)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      slot_in   = slot_ff;
      cur_in    = cur_ff;
      used_in   = used_ff;
      failed_in = failed_ff;
      item_in   = item_ff;
      strobe_in = 1'b0;
      found_in  = found_ff;
      status_in = status_ff;
      pop       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               item_in  = head.item;
               slot_in  = slot_calc;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (advance) begin
               if (child_rd != '0) begin
                  cur_in = child_rd;
               end else if (alloc) begin
                  cur_in  = NW'(used_ff);
                  used_in = used_ff + 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            state_in = item_ff.last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (item_ff.command == CMD_INSERT) begin
               strobe_in = 1'b1;
               found_in  = 1'b0;
               status_in = failed_ff;
               cur_in    = '0;
               failed_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            strobe_in = 1'b1;
            found_in  = !failed_ff && mark_rd;
            status_in = 1'b0;
            cur_in    = '0;
            failed_in = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         sweep_ff  <= '0;
         cur_ff    <= '0;
         used_ff   <= (NW+1)'(1);
         failed_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         cur_ff    <= cur_in;
         used_ff   <= used_in;
         failed_ff <= failed_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      item_ff   <= item_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   assign clearing   = state_ff == ST_CLEAR;
   assign rsp_strobe = strobe_ff;
   assign rsp_found  = found_ff;
   assign rsp_status = status_ff;

endmodule

// File: hdl/trie_dictionary_insert_search.sv
// top level of the trie dictionary: front end, queue and back end
//
// An ALPHABET_SIZE-way trie (26 at the defaults) in a pool of NODE_COUNT
// nodes. Words arrive one letter per transaction (start while busy is low);
// the first letter's command picks insert or search and req_last ends the
// word. Only the last letter gives a result, shown on rsp_found/rsp_status
// for one cycle with rsp_strobe; the receiver cannot stall it. A two-entry
// queue takes letters while the back end works. For a letter that does not
// end a word the back end does one registered child-table read, then the
// decision and any child write; a last letter adds the word-end mark write
// for an insert, or the mark read for a search. After reset, busy stays
// high while the child table and word-end marks are swept to zero.
module trie_dictionary_insert_search #(
   parameter int NODE_COUNT    = tdi_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = tdi_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic [tdi_pkg::LETTER_W-1:0] req_letter,
   input  logic                         req_last,
   output logic                         rsp_strobe,
   output logic                         rsp_found,
   output logic                         rsp_status
);
   import tdi_pkg::*;

   logic     accept;
   logic     q_full;
   logic     pop;
   logic     clearing;
   item_type front_item;
   head_type head;

   // no transaction while the queue is full or the pool is being swept
   assign busy   = q_full || clearing;
   assign accept = start && !busy;

   tdi_front #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_command (req_command),
      .req_letter  (req_letter),
      .req_last    (req_last),
      .item        (front_item)
   );

   tdi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (pop),
      .head      (head),
      .full      (q_full)
   );

   tdi_back #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status)
   );

`ifndef SYNTHESIS
   // results of two words are never in adjacent cycles
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results in adjacent cycles");

   // a search never flags a full pool and an insert never reports found
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_found && rsp_status))
      else $error("found and pool full together");

   // no result while the pool is being swept
   a_no_result_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_strobe)
      else $error("result during clearing sweep");

   // the back end never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule
